@@ rtl/rpn_pkg.sv @@
// -----------------------------------------------------------------------------
// rpn_pkg: shared types and constants for the RPN stack calculator
// Operation and status codes, controller/datapath command and status bundles,
// and the Q16.16 saturation helper.
// -----------------------------------------------------------------------------
package rpn_pkg;

    // Payload widths
    localparam int OP_W     = 3;
    localparam int Q_W      = 32;
    localparam int DEPTH_W  = 5;
    localparam int STATUS_W = 3;

    // Default stack capacity
    localparam int STACK_DEPTH_DEF = 16;

    // Divider iteration count (one quotient bit per cycle)
    localparam int DIV_STEPS = 32;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    // Saturation bounds
    localparam logic signed [47:0] Q_MAX48 = 48'sh0000_7FFF_FFFF;
    localparam logic signed [47:0] Q_MIN48 = 48'shFFFF_8000_0000;
    localparam logic [Q_W-1:0]     Q_MAX   = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0]     Q_MIN   = 32'h8000_0000;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_UNDER   = 3'd1,
        ST_FULL    = 3'd2,
        ST_DIVZERO = 3'd3,
        ST_SAT     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FETCH,
        S_MUL,
        S_DIV,
        S_DIVFIN,
        S_WRITE,
        S_OUT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic    load_in;
        logic    push;
        logic    rd_issue;
        logic    alu;
        logic    mul_prod;
        logic    mul_fin;
        logic    div_init;
        logic    div_step;
        logic    div_fin;
        logic    write_back;
        logic    err_set;
        status_t err_code;
        logic    load_out;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        op_t  op;
        logic full;
        logic under;
        logic b_zero;
        logic div_early_sat;
        logic div_last;
    } sts_t;

    typedef struct packed {
        logic           sat;
        logic [Q_W-1:0] val;
    } clamp_t;

    // Clamp a widened signed result to the Q16.16 range
    function automatic clamp_t clamp_q(input logic signed [47:0] v);
        clamp_t r;
        if (v > Q_MAX48)
        begin
            r.sat = 1'b1;
            r.val = Q_MAX;
        end
        else if (v < Q_MIN48)
        begin
            r.sat = 1'b1;
            r.val = Q_MIN;
        end
        else
        begin
            r.sat = 1'b0;
            r.val = v[Q_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/rpn_token_if.sv @@
// -----------------------------------------------------------------------------
// rpn_token_if: input channel of the RPN stack calculator
// Carries one token item: operation code and Q16.16 operand.
// -----------------------------------------------------------------------------
interface rpn_token_if import rpn_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [OP_W-1:0]       op;
    logic signed [Q_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink (input valid, input op, input value, output ready);
endinterface

@@ rtl/rpn_result_if.sv @@
// -----------------------------------------------------------------------------
// rpn_result_if: output channel of the RPN stack calculator
// Carries one result item: top of stack, depth and status.
// -----------------------------------------------------------------------------
interface rpn_result_if import rpn_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic signed [Q_W-1:0] top_value;
    logic [DEPTH_W-1:0]    depth;
    logic [STATUS_W-1:0]   status;

    modport source (output valid, output top_value, output depth, output status, input ready);
    modport sink (input valid, input top_value, input depth, input status, output ready);
endinterface

@@ rtl/rpn_ctrl.sv @@
// -----------------------------------------------------------------------------
// rpn_ctrl: sequencer of the RPN stack calculator
// Walks each item through decode and, for the arithmetic ops, operand fetch,
// execute and write-back, and owns the output valid flag.
// -----------------------------------------------------------------------------
module rpn_ctrl import rpn_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t cmd,
    input  sts_t sts
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                case (sts.op)
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                        state_next = sts.under ? S_OUT : S_FETCH;
                    default:
                        state_next = S_OUT;
                endcase
            end
            S_FETCH:
            begin
                case (sts.op)
                    OP_ADD, OP_SUB:
                        state_next = S_WRITE;
                    OP_MUL:
                        state_next = S_MUL;
                    OP_DIV:
                    begin
                        if (sts.b_zero)
                            state_next = S_OUT;
                        else if (sts.div_early_sat)
                            state_next = S_WRITE;
                        else
                            state_next = S_DIV;
                    end
                    default:
                        state_next = S_OUT;
                endcase
            end
            S_MUL:
                state_next = S_WRITE;
            S_DIV:
            begin
                if (sts.div_last)
                    state_next = S_DIVFIN;
            end
            S_DIVFIN:
                state_next = S_WRITE;
            S_WRITE:
                state_next = S_OUT;
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Command outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            S_DECODE:
            begin
                case (sts.op)
                    OP_PUSH:
                    begin
                        if (sts.full)
                        begin
                            cmd.err_set  = 1'b1;
                            cmd.err_code = ST_FULL;
                        end
                        else
                            cmd.push = 1'b1;
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                    begin
                        if (sts.under)
                        begin
                            cmd.err_set  = 1'b1;
                            cmd.err_code = ST_UNDER;
                        end
                        else
                            cmd.rd_issue = 1'b1;
                    end
                    default:
                        cmd = '0;
                endcase
            end
            S_FETCH:
            begin
                case (sts.op)
                    OP_ADD, OP_SUB:
                        cmd.alu = 1'b1;
                    OP_MUL:
                        cmd.mul_prod = 1'b1;
                    OP_DIV:
                    begin
                        if (sts.b_zero)
                        begin
                            cmd.err_set  = 1'b1;
                            cmd.err_code = ST_DIVZERO;
                        end
                        else
                            cmd.div_init = 1'b1;
                    end
                    default:
                        cmd = '0;
                endcase
            end
            S_MUL:
                cmd.mul_fin = 1'b1;
            S_DIV:
                cmd.div_step = 1'b1;
            S_DIVFIN:
                cmd.div_fin = 1'b1;
            S_WRITE:
                cmd.write_back = 1'b1;
            S_OUT:
                cmd.load_out = !out_valid_reg || out_ready;
            default:
                cmd = '0;
        endcase
    end

    // Output valid: set on load, drop once taken
    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

@@ rtl/rpn_dp.sv @@
// -----------------------------------------------------------------------------
// rpn_dp: datapath of the RPN stack calculator
// Operand stack memory with a cached top entry, add/subtract, multiplier,
// radix-2 restoring divider, saturation and the output register.
// -----------------------------------------------------------------------------
module rpn_dp import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    output sts_t                   sts,
    input  logic [OP_W-1:0]        op,
    input  logic signed [Q_W-1:0]  value,
    output logic signed [Q_W-1:0]  top_value,
    output logic [DEPTH_W-1:0]     depth,
    output logic [STATUS_W-1:0]    status
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int XW = CW + DEPTH_W;

    // Stack memory
    logic [Q_W-1:0] mem [STACK_DEPTH];
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [Q_W-1:0] mem_wdata;
    logic [AW-1:0]  rd_addr;
    logic [Q_W-1:0] rd_data_reg;

    // Item and stack state
    logic [OP_W-1:0]       op_reg,    op_next;
    logic [Q_W-1:0]        value_reg, value_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [Q_W-1:0]        top_reg,   top_next;
    logic [CW-1:0]         count_m2;

    // Execute state
    logic [Q_W-1:0]        res_reg,  res_next;
    logic                  sat_reg,  sat_next;
    logic signed [63:0]    prod_reg, prod_next;
    logic [Q_W:0]          rem_reg,  rem_next;
    logic [Q_W-1:0]        dvd_reg,  dvd_next;
    logic [Q_W-1:0]        quo_reg,  quo_next;
    logic [Q_W-1:0]        dmag_reg, dmag_next;
    logic                  neg_reg,  neg_next;
    logic [DCNT_W-1:0]     dcnt_reg, dcnt_next;
    status_t               status_reg, status_next;

    // Output register
    logic [Q_W-1:0]        out_top_reg,    out_top_next;
    logic [DEPTH_W-1:0]    out_depth_reg,  out_depth_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;

    // Operand views
    logic signed [Q_W-1:0] a_s;
    logic signed [Q_W-1:0] b_s;
    logic [Q_W-1:0]        a_mag;
    logic [Q_W-1:0]        b_mag;
    logic [Q_W:0]          sum33;
    clamp_t                alu_c;
    clamp_t                mul_c;
    logic [Q_W:0]          shifted;
    logic                  ge;
    logic [XW-1:0]         count_ext;

    assign count_m2 = count_reg - CW'(2);
    assign rd_addr  = count_m2[AW-1:0];

    assign a_s   = $signed(rd_data_reg);
    assign b_s   = $signed(top_reg);
    assign a_mag = a_s[Q_W-1] ? (Q_W'(0) - rd_data_reg) : rd_data_reg;
    assign b_mag = b_s[Q_W-1] ? (Q_W'(0) - top_reg) : top_reg;

    // Status toward the controller
    assign sts.op            = op_t'(op_reg);
    assign sts.full          = (count_reg == CW'(STACK_DEPTH));
    assign sts.under         = (count_reg < CW'(2));
    assign sts.b_zero        = (top_reg == '0);
    assign sts.div_early_sat = ({16'h0000, a_mag[Q_W-1:16]} >= b_mag);
    assign sts.div_last      = (dcnt_reg == DCNT_W'(DIV_STEPS - 1));

    // Add or subtract, widened then clamped
    always_comb
    begin
        if (op_t'(op_reg) == OP_SUB)
            sum33 = {a_s[Q_W-1], a_s} - {b_s[Q_W-1], b_s};
        else
            sum33 = {a_s[Q_W-1], a_s} + {b_s[Q_W-1], b_s};
        alu_c = clamp_q($signed({{15{sum33[Q_W]}}, sum33}));
    end

    // Product scaled by 2^-16 with floor, then clamped
    assign mul_c = clamp_q($signed(prod_reg[63:16]));

    // Divider trial subtract
    assign shifted = {rem_reg[Q_W-1:0], dvd_reg[Q_W-1]};
    assign ge      = (shifted >= {1'b0, dmag_reg});

    // Memory write port select
    always_comb
    begin
        mem_we    = cmd.push || cmd.write_back;
        mem_waddr = cmd.push ? count_reg[AW-1:0] : rd_addr;
        mem_wdata = cmd.push ? value_reg : res_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_issue)
            rd_data_reg <= mem[rd_addr];
    end

    // Item latch, stack count and cached top
    always_comb
    begin
        op_next     = op_reg;
        value_next  = value_reg;
        count_next  = count_reg;
        top_next    = top_reg;
        status_next = status_reg;
        if (cmd.load_in)
        begin
            op_next     = op;
            value_next  = value;
            status_next = ST_OK;
        end
        if (cmd.push)
        begin
            top_next   = value_reg;
            count_next = count_reg + CW'(1);
        end
        if (cmd.write_back)
        begin
            top_next    = res_reg;
            count_next  = count_reg - CW'(1);
            status_next = sat_reg ? ST_SAT : ST_OK;
        end
        if (cmd.err_set)
            status_next = cmd.err_code;
    end

    // Execute: add/sub, multiply, divide
    always_comb
    begin
        res_next  = res_reg;
        sat_next  = sat_reg;
        prod_next = prod_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        dmag_next = dmag_reg;
        neg_next  = neg_reg;
        dcnt_next = dcnt_reg;
        if (cmd.alu)
        begin
            res_next = alu_c.val;
            sat_next = alu_c.sat;
        end
        if (cmd.mul_prod)
            prod_next = a_s * b_s;
        if (cmd.mul_fin)
        begin
            res_next = mul_c.val;
            sat_next = mul_c.sat;
        end
        // Quotient of at least 2^32 is known to saturate up front
        if (cmd.div_init)
        begin
            rem_next  = {17'h0_0000, a_mag[Q_W-1:16]};
            dvd_next  = {a_mag[15:0], 16'h0000};
            quo_next  = '0;
            dmag_next = b_mag;
            neg_next  = a_s[Q_W-1] ^ b_s[Q_W-1];
            dcnt_next = '0;
            sat_next  = 1'b1;
            res_next  = (a_s[Q_W-1] ^ b_s[Q_W-1]) ? Q_MIN : Q_MAX;
        end
        if (cmd.div_step)
        begin
            rem_next  = ge ? (shifted - {1'b0, dmag_reg}) : shifted;
            dvd_next  = {dvd_reg[Q_W-2:0], 1'b0};
            quo_next  = {quo_reg[Q_W-2:0], ge};
            dcnt_next = dcnt_reg + DCNT_W'(1);
        end
        // Apply sign to the magnitude quotient and clamp
        if (cmd.div_fin)
        begin
            if (neg_reg)
            begin
                sat_next = (quo_reg > Q_MIN);
                res_next = (quo_reg > Q_MIN) ? Q_MIN : (Q_W'(0) - quo_reg);
            end
            else
            begin
                sat_next = quo_reg[Q_W-1];
                res_next = quo_reg[Q_W-1] ? Q_MAX : quo_reg;
            end
        end
    end

    // Output register load
    assign count_ext = XW'(count_reg);

    always_comb
    begin
        out_top_next    = out_top_reg;
        out_depth_next  = out_depth_reg;
        out_status_next = out_status_reg;
        if (cmd.load_out)
        begin
            out_top_next    = (count_reg == '0) ? '0 : top_reg;
            out_depth_next  = count_ext[DEPTH_W-1:0];
            out_status_next = status_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            dcnt_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            dcnt_reg  <= dcnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        value_reg      <= value_next;
        top_reg        <= top_next;
        status_reg     <= status_next;
        res_reg        <= res_next;
        sat_reg        <= sat_next;
        prod_reg       <= prod_next;
        rem_reg        <= rem_next;
        dvd_reg        <= dvd_next;
        quo_reg        <= quo_next;
        dmag_reg       <= dmag_next;
        neg_reg        <= neg_next;
        out_top_reg    <= out_top_next;
        out_depth_reg  <= out_depth_next;
        out_status_reg <= out_status_next;
    end

    assign top_value = $signed(out_top_reg);
    assign depth     = out_depth_reg;
    assign status    = out_status_reg;

endmodule

@@ rtl/rpn_stack_calculator.sv @@
// -----------------------------------------------------------------------------
// rpn_stack_calculator: postfix evaluator over a Q16.16 operand stack
// Each token item either pushes its value or pops the two top entries and
// pushes (second op top) for add, subtract, multiply or divide. Every item
// returns one result item: new top (zero when empty), depth and status.
// Channels: token (op, value) in, result (top_value, depth, status) out,
// both valid/ready. One item is in work at a time; a new token is taken
// while the previous result still waits in the output register.
// Steps from token accept to result load: push, ignored op, full and
// underflow go from decode to the output register; a divide by zero stops
// after operand fetch; add/subtract run fetch and write-back, multiply adds a
// product step, divide 32 iterations of the one-bit restoring divider and a
// sign fix-up. A divide whose quotient is 2^32 or more skips the iterations and
// saturates. The next token is taken in the cycle after the result is loaded.
// Reset empties the stack; stack memory is not cleared. A stalled receiver
// holds the result; the next item waits for the output register to drain.
// -----------------------------------------------------------------------------
module rpn_stack_calculator import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input logic         clk,
    input logic         rst_n,
    rpn_token_if.sink   token,
    rpn_result_if.source result
);

    cmd_t cmd;
    sts_t sts;

    rpn_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (token.valid),
        .in_ready  (token.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    rpn_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .op        (token.op),
        .value     (token.value),
        .top_value (result.top_value),
        .depth     (result.depth),
        .status    (result.status)
    );

endmodule

@@ dv/rpn_calc_checker.sv @@
// -----------------------------------------------------------------------------
// rpn_calc_checker: result checker for the RPN stack calculator
// Watches the token and result channels and keeps its own Q16.16 operand stack.
// For every accepted token item it computes the new top, depth and status.
// Every accepted result item is compared field by field against the oldest
// outstanding prediction.
// -----------------------------------------------------------------------------
module rpn_calc_checker import rpn_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    rpn_token_if  token,
    rpn_result_if result,
    output int    fail_count,
    output int    pending
);

    localparam longint Q_HI = 64'sd2147483647;
    localparam longint Q_LO = -64'sd2147483648;

    typedef struct packed {
        logic [Q_W-1:0]     top_value;
        logic [DEPTH_W-1:0] depth;
        status_t            status;
    } calc_result_t;

    // Shadow operand stack
    logic [Q_W-1:0] stack_mem [STACK_DEPTH_DEF];
    int             stack_cnt = 0;

    calc_result_t   due_results [$];
    int             mismatches = 0;
    int             due_count = 0;

    assign fail_count = mismatches;
    assign pending    = due_count;

    // Apply one token to the shadow stack and return the result it produces
    function automatic calc_result_t evaluate_token(input logic [OP_W-1:0] code,
                                                    input logic [Q_W-1:0] operand);
        calc_result_t r;
        longint       a;
        longint       b;
        longint       wide;
        logic [Q_W-1:0] clamped;
        r.status = ST_OK;
        if (code == OP_PUSH)
        begin
            if (stack_cnt >= STACK_DEPTH_DEF)
                r.status = ST_FULL;
            else
            begin
                stack_mem[stack_cnt] = operand;
                stack_cnt++;
            end
        end
        else if (code <= OP_DIV)
        begin
            if (stack_cnt < 2)
                r.status = ST_UNDER;
            else
            begin
                b = $signed(stack_mem[stack_cnt - 1]);
                a = $signed(stack_mem[stack_cnt - 2]);
                if (code == OP_DIV && b == 0)
                    r.status = ST_DIVZERO;
                else
                begin
                    case (code)
                        OP_ADD:  wide = a + b;
                        OP_SUB:  wide = a - b;
                        // arithmetic shift floors the scaled product
                        OP_MUL:  wide = (a * b) >>> 16;
                        // signed divide truncates toward zero
                        default: wide = (a * 65536) / b;
                    endcase
                    if (wide > Q_HI)
                    begin
                        clamped  = Q_MAX;
                        r.status = ST_SAT;
                    end
                    else if (wide < Q_LO)
                    begin
                        clamped  = Q_MIN;
                        r.status = ST_SAT;
                    end
                    else
                        clamped = wide[Q_W-1:0];
                    stack_mem[stack_cnt - 2] = clamped;
                    stack_cnt--;
                end
            end
        end
        // unused op codes fall through with the stack untouched
        r.top_value = (stack_cnt > 0) ? stack_mem[stack_cnt - 1] : '0;
        r.depth     = DEPTH_W'(stack_cnt);
        return r;
    endfunction

    // Check results first: a result never belongs to a token taken at the same edge
    always @(posedge clk)
    begin
        calc_result_t want;
        if (rst_n)
        begin
            if (result.valid && result.ready)
            begin
                if (due_results.size() == 0)
                begin
                    $display("%0t: unexpected result top_value %h depth %0d status %0d",
                             $time, result.top_value, result.depth, result.status);
                    mismatches++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (result.top_value !== want.top_value)
                    begin
                        $display("%0t: top_value expected %h, got %h",
                                 $time, want.top_value, result.top_value);
                        mismatches++;
                    end
                    if (result.depth !== want.depth)
                    begin
                        $display("%0t: depth expected %0d, got %0d",
                                 $time, want.depth, result.depth);
                        mismatches++;
                    end
                    if (result.status !== want.status)
                    begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, result.status);
                        mismatches++;
                    end
                end
            end
            if (token.valid && token.ready)
                due_results.push_back(evaluate_token(token.op, token.value));
            due_count = due_results.size();
        end
    end

endmodule

@@ dv/tb.sv @@
// -----------------------------------------------------------------------------
// tb: testbench top for the RPN stack calculator
// Drives token items in random bursts (a directed opening, then random
// expressions, stack fills, unwinds and divide-by-zero patterns) while the
// result side stalls on its own pattern. A checker beside the block predicts
// and compares every result item; this module only makes stimulus and decides.
// -----------------------------------------------------------------------------
module tb import rpn_pkg::*;
();

    localparam int RANDOM_ITEMS   = 520;
    localparam int HOLD_CYCLES    = 150;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 50;

    // Op codes the block ignores
    localparam logic [OP_W-1:0] OP_RSVD_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_HI = 3'd7;

    logic clk = 1'b0;
    logic rst_n;
    logic hold_req;
    int   fail_count;
    int   pending;
    int   sent = 0;
    int   burst_left = 0;

    rpn_token_if  tok_if ();
    rpn_result_if res_if ();

    rpn_stack_calculator u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .token  (tok_if),
        .result (res_if)
    );

    rpn_calc_checker u_calc_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .token      (tok_if),
        .result     (res_if),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Pick an operand: extremes, tiny fractions, small integers or anything
    function automatic logic [Q_W-1:0] random_q();
        int whole;
        whole = int'($urandom_range(0, 16)) - 8;
        case ($urandom_range(0, 7))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3:       return {{16{1'($urandom_range(0, 1))}}, 16'($urandom)};
            4, 5:    return whole <<< 16;
            default: return $urandom;
        endcase
    endfunction

    // Offer one token item, opening a new burst after a random gap when due
    task automatic send_token(input logic [OP_W-1:0] code, input logic [Q_W-1:0] operand);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 10);
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                tok_if.valid <= 1'b0;
                tok_if.op    <= OP_W'($urandom);
                tok_if.value <= $urandom;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        tok_if.valid <= 1'b1;
        tok_if.op    <= code;
        tok_if.value <= operand;
        do
            @(posedge clk);
        while (!tok_if.ready);
        sent++;
    endtask

    // Hold the token side idle until every outstanding result has come back
    task automatic wait_drained();
        @(negedge clk);
        tok_if.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        burst_left = 0;
    endtask

    // Result side: random stall patterns in turn; long hold on request
    initial
    begin
        int         mode;
        int         left;
        int         phase;
        bit         hold_done;
        logic [7:0] mask;
        res_if.ready = 1'b0;
        mode      = 0;
        left      = 0;
        phase     = 0;
        hold_done = 1'b0;
        mask      = 8'h01;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 80);
                mask = 8'($urandom) | 8'h01;
            end
            left--;
            case (mode)
                0:       res_if.ready <= 1'b1;
                1:       res_if.ready <= 1'($urandom_range(0, 1));
                2:       res_if.ready <= ($urandom_range(0, 3) == 0);
                default:
                begin
                    res_if.ready <= mask[phase % 8];
                    phase++;
                end
            endcase
        end
    end

    // Watchdog: end the run when nothing moves on either channel for too long
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((tok_if.valid && tok_if.ready) || (res_if.valid && res_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb NOT OK");
        $finish;
    end

    // Stimulus and verdict
    initial
    begin
        int  directed;
        int  k;
        bit  held;
        bit  drained;
        tok_if.valid = 1'b0;
        tok_if.op    = OP_PUSH;
        tok_if.value = '0;
        rst_n        = 1'b0;
        hold_req     = 1'b0;
        held         = 1'b0;
        drained      = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed opening: underflow, saturation both ways, divide by zero,
        // floor rounding of a negative product, ignored op codes
        send_token(OP_ADD, Q_MAX);
        send_token(OP_PUSH, Q_MAX);
        send_token(OP_DIV, '0);
        send_token(OP_PUSH, 32'h0001_0000);
        send_token(OP_ADD, '1);
        send_token(OP_PUSH, Q_MIN);
        send_token(OP_SUB, '0);
        send_token(OP_PUSH, Q_MIN);
        send_token(OP_ADD, '0);
        send_token(OP_PUSH, Q_MAX);
        send_token(OP_SUB, '0);
        send_token(OP_PUSH, 32'h0000_0001);
        send_token(OP_SUB, '0);
        send_token(OP_PUSH, '0);
        send_token(OP_DIV, '1);
        send_token(OP_MUL, '0);
        send_token(OP_PUSH, Q_MIN);
        send_token(OP_PUSH, 32'hFFFF_0000);
        send_token(OP_DIV, '0);
        send_token(OP_PUSH, 32'hFFFF_FFFF);
        send_token(OP_MUL, '0);
        for (int c = OP_RSVD_LO; c <= OP_RSVD_HI; c++)
            send_token(OP_W'(c), (c == OP_RSVD_LO) ? Q_MIN : ~Q_MIN);
        send_token(OP_PUSH, Q_MIN);
        send_token(OP_MUL, '0);
        directed = sent;

        // Random part
        while (sent < directed + RANDOM_ITEMS)
        begin
            if (!held && sent >= directed + 150)
            begin
                hold_req = 1'b1;
                held     = 1'b1;
            end
            if (!drained && sent >= directed + 330)
            begin
                wait_drained();
                drained = 1'b1;
            end
            case ($urandom_range(0, 9))
                // fill past capacity
                0: repeat (18) send_token(OP_PUSH, random_q());
                // unwind past empty
                1: repeat (18) send_token(OP_W'($urandom_range(OP_ADD, OP_DIV)), random_q());
                2:
                begin
                    send_token(OP_PUSH, random_q());
                    send_token(OP_PUSH, '0);
                    send_token(OP_DIV, random_q());
                end
                3, 4:
                begin
                    send_token(OP_PUSH, random_q());
                    send_token(OP_PUSH, random_q());
                    send_token(OP_W'($urandom_range(OP_ADD, OP_DIV)), random_q());
                end
                default:
                begin
                    k = $urandom_range(0, 19);
                    if (k < 9)
                        send_token(OP_PUSH, random_q());
                    else if (k < 18)
                        send_token(OP_W'($urandom_range(OP_ADD, OP_DIV)), random_q());
                    else
                        send_token(OP_W'($urandom_range(OP_RSVD_LO, OP_RSVD_HI)),
                                   random_q());
                end
            endcase
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
